// File: rtl/core/uniform_mod769_rejection_sampler_top_assert.svh
// Assertion macros shared by the sampler modules.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef UNIFORM_MOD769_REJECTION_SAMPLER_TOP_ASSERT_SVH
`define UNIFORM_MOD769_REJECTION_SAMPLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define UMRS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define UMRS_NEVER(label, cond, msg) \
	`UMRS_ASSERT(label, !(cond), msg)

`else

`define UMRS_ASSERT(label, prop, msg)

`define UMRS_NEVER(label, cond, msg)

`endif

`endif

// File: rtl/core/umrs_pkg.sv
package umrs_pkg;

	localparam int POLY_COEFFS       = 1024;
	localparam int BIG_CHUNK_BYTES   = 1368;
	localparam int SMALL_CHUNK_BYTES = 30;

	localparam int KEPT_WORDS = (POLY_COEFFS - 4) / 5;
	localparam int BIG_USED   = (BIG_CHUNK_BYTES / 6) * 6;
	localparam int SMALL_USED = (SMALL_CHUNK_BYTES / 5) * 5;

	localparam int BYTE_W  = 8;
	localparam int COEFF_W = 10;
	localparam int IDX_W   = 10;
	localparam int WORD_W  = 48;
	localparam int TAIL_W  = 40;
	localparam int CHUNK_W = $clog2(((BIG_CHUNK_BYTES > SMALL_CHUNK_BYTES) ?
		BIG_CHUNK_BYTES : SMALL_CHUNK_BYTES) + 1);
	localparam int KEPT_W  = $clog2(KEPT_WORDS + 1);

	localparam logic [COEFF_W-1:0] Q_MOD    = 10'd769;
	localparam logic [WORD_W-1:0]  Q_POW5   = 48'd268925323054849;
	localparam logic [TAIL_W-1:0]  Q_POW4   = 40'd349707832321;
	localparam logic [BYTE_W-1:0]  TOP_MASK = 8'h7F;

	// Index of the first of the four tail coefficients, reduced to the index width.
	localparam logic [IDX_W-1:0] TAIL_BASE = IDX_W'(POLY_COEFFS - 4);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(POLY_COEFFS - 1);

	localparam int JOB_DEPTH = 4;
	localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
	localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

	// The long division by 769 works on one 16-bit chunk of the word per lane.
	localparam int LIMB_W = 16;
	localparam int DIVIN_W = COEFF_W + LIMB_W;
	localparam int RECIP_SHIFT = 32;
	localparam logic [22:0] DIV_RECIP = 23'((64'd1 << RECIP_SHIFT) / 64'd769);
	localparam int PROD_W = DIVIN_W + 23;

	typedef struct packed {
		logic [WORD_W-1:0] x;
		logic [IDX_W-1:0]  base;
		logic              tail;
	} job_t;

	typedef struct packed {
		logic [LIMB_W-1:0]  q;
		logic [COEFF_W-1:0] r;
	} divmod_t;

	// Quotient and remainder of v by 769, valid for v below 769 * 2^16.
	// The reciprocal estimate is at most one low, so one correction step suffices.
	function automatic divmod_t div769(input logic [DIVIN_W-1:0] v);
		logic [PROD_W-1:0] prod;
		logic [16:0]       q0;
		logic [26:0]       back;
		logic [26:0]       rem;
		divmod_t           res;
		prod = PROD_W'(v) * PROD_W'(DIV_RECIP);
		q0   = prod[RECIP_SHIFT +: 17];
		back = 27'({q0, 9'b0}) + 27'({q0, 8'b0}) + 27'(q0);
		rem  = 27'(v) - back;
		if (rem >= 27'(Q_MOD)) begin
			res.q = LIMB_W'(q0 + 17'd1);
			res.r = COEFF_W'(rem - 27'(Q_MOD));
		end else begin
			res.q = q0[LIMB_W-1:0];
			res.r = rem[COEFF_W-1:0];
		end
		return res;
	endfunction

endpackage

// File: rtl/core/umrs_in_if.sv
interface umrs_in_if;
	logic                          valid;
	logic                          ready;
	logic [umrs_pkg::BYTE_W-1:0]   stream_byte;
	logic                          new_stream;

	modport source(output valid, output stream_byte, output new_stream, input ready);
	modport sink(input valid, input stream_byte, input new_stream, output ready);
endinterface

// File: rtl/core/umrs_out_if.sv
interface umrs_out_if;
	logic                          valid;
	logic                          ready;
	logic [umrs_pkg::COEFF_W-1:0]  coeff;
	logic [umrs_pkg::IDX_W-1:0]    coeff_index;
	logic                          last;

	modport source(output valid, output coeff, output coeff_index, output last, input ready);
	modport sink(input valid, input coeff, input coeff_index, input last, output ready);
endinterface

// File: rtl/core/umrs_front.sv
module umrs_front (
	input  logic            clk,
	input  logic            arst_n,
	umrs_in_if.sink         stream,
	input  logic            full,
	output logic            push,
	output umrs_pkg::job_t  job
);

	typedef enum logic [3:0] {
		PH_ONE   = 4'b0001,
		PH_DRAIN = 4'b0010,
		PH_TWO   = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

	phase_t                              phase_q, c_phase, n_phase;
	logic [umrs_pkg::WORD_W-1:0]         acc_q, c_acc, n_acc;
	logic [2:0]                          biw_q, c_biw, n_biw;
	logic [umrs_pkg::CHUNK_W-1:0]        cnt_q, c_cnt, n_cnt;
	logic [umrs_pkg::KEPT_W-1:0]         kept_q, c_kept, n_kept;
	logic [umrs_pkg::IDX_W-1:0]          base_q, c_base, n_base;
	logic [umrs_pkg::BYTE_W-1:0]         b;
	logic                                accept;
	logic                                keep;

	assign stream.ready = !full;
	assign accept = stream.valid && stream.ready;
	assign push = accept && keep;

	always_comb begin
		if (stream.new_stream) begin
			c_phase = PH_ONE;
			c_acc   = '0;
			c_biw   = '0;
			c_cnt   = '0;
			c_kept  = '0;
			c_base  = '0;
		end else begin
			c_phase = phase_q;
			c_acc   = acc_q;
			c_biw   = biw_q;
			c_cnt   = cnt_q;
			c_kept  = kept_q;
			c_base  = base_q;
		end

		n_phase  = c_phase;
		n_acc    = c_acc;
		n_biw    = c_biw;
		n_cnt    = c_cnt;
		n_kept   = c_kept;
		n_base   = c_base;
		keep     = 1'b0;
		job.x    = c_acc;
		job.base = c_base;
		job.tail = 1'b0;
		b        = stream.stream_byte;

		case (c_phase)
			PH_ONE: begin
				if (c_cnt < umrs_pkg::CHUNK_W'(umrs_pkg::BIG_USED)) begin
					for (int i = 0; i < 6; i++) begin
						if (c_biw == 3'(i)) begin
							n_acc[8*i +: 8] = b;
						end
					end
					if (c_biw == 3'd5) begin
						job.x = n_acc;
						n_acc = '0;
						n_biw = '0;
						if (job.x < umrs_pkg::Q_POW5) begin
							keep   = 1'b1;
							n_kept = c_kept + 1'b1;
							n_base = c_base + umrs_pkg::IDX_W'(5);
						end
					end else begin
						n_biw = c_biw + 3'd1;
					end
				end
				if (c_cnt == umrs_pkg::CHUNK_W'(umrs_pkg::BIG_CHUNK_BYTES - 1)) begin
					n_cnt = '0;
				end else begin
					n_cnt = c_cnt + 1'b1;
				end
				if (n_kept >= umrs_pkg::KEPT_W'(umrs_pkg::KEPT_WORDS)) begin
					n_acc   = '0;
					n_biw   = '0;
					n_phase = (n_cnt == '0) ? PH_TWO : PH_DRAIN;
				end
			end
			PH_DRAIN: begin
				if (c_cnt == umrs_pkg::CHUNK_W'(umrs_pkg::BIG_CHUNK_BYTES - 1)) begin
					n_cnt   = '0;
					n_phase = PH_TWO;
				end else begin
					n_cnt = c_cnt + 1'b1;
				end
			end
			PH_TWO: begin
				if (c_cnt == umrs_pkg::CHUNK_W'(umrs_pkg::SMALL_CHUNK_BYTES - 1)) begin
					n_cnt = '0;
				end else begin
					n_cnt = c_cnt + 1'b1;
				end
				if (c_cnt < umrs_pkg::CHUNK_W'(umrs_pkg::SMALL_USED)) begin
					// The fifth byte of a tail word loses its top bit.
					for (int i = 0; i < 5; i++) begin
						if (c_biw == 3'(i)) begin
							n_acc[8*i +: 8] = (i == 4) ? (b & umrs_pkg::TOP_MASK) : b;
						end
					end
					if (c_biw == 3'd4) begin
						job.x = n_acc;
						n_acc = '0;
						n_biw = '0;
						if (job.x[umrs_pkg::TAIL_W-1:0] < umrs_pkg::Q_POW4) begin
							keep     = 1'b1;
							job.base = umrs_pkg::TAIL_BASE;
							job.tail = 1'b1;
							n_phase  = PH_DONE;
							n_cnt    = '0;
						end
					end else begin
						n_biw = c_biw + 3'd1;
					end
				end
			end
			PH_DONE: begin
				n_phase = PH_DONE;
			end
			default: begin
				n_phase = PH_ONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ONE;
			acc_q   <= '0;
			biw_q   <= '0;
			cnt_q   <= '0;
			kept_q  <= '0;
			base_q  <= '0;
		end else if (accept) begin
			phase_q <= n_phase;
			acc_q   <= n_acc;
			biw_q   <= n_biw;
			cnt_q   <= n_cnt;
			kept_q  <= n_kept;
			base_q  <= n_base;
		end
	end

endmodule

// File: rtl/core/umrs_job_fifo.sv
`include "uniform_mod769_rejection_sampler_top_assert.svh"

module umrs_job_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  umrs_pkg::job_t  job_in,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output umrs_pkg::job_t  job_out
);

	umrs_pkg::job_t                   mem_q [umrs_pkg::JOB_DEPTH];
	logic [umrs_pkg::JOB_PTR_W-1:0]   wr_q;
	logic [umrs_pkg::JOB_PTR_W-1:0]   rd_q;
	logic [umrs_pkg::JOB_CNT_W-1:0]   count_q;

	assign full    = (count_q == umrs_pkg::JOB_CNT_W'(umrs_pkg::JOB_DEPTH));
	assign valid   = (count_q != '0);
	assign job_out = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == umrs_pkg::JOB_PTR_W'(umrs_pkg::JOB_DEPTH - 1)) ?
					'0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == umrs_pkg::JOB_PTR_W'(umrs_pkg::JOB_DEPTH - 1)) ?
					'0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`UMRS_NEVER(a_push_when_full, push && full, "job pushed into a full queue")
	`UMRS_NEVER(a_pop_when_empty, pop && !valid, "job popped from an empty queue")
	`UMRS_ASSERT(a_count_bound, count_q <= umrs_pkg::JOB_CNT_W'(umrs_pkg::JOB_DEPTH), "queue count out of range")

endmodule

// File: rtl/core/umrs_digit_back.sv
`include "uniform_mod769_rejection_sampler_top_assert.svh"

module umrs_digit_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	input  umrs_pkg::job_t  job,
	output logic            job_pop,
	umrs_out_if.source      coeffs
);

	localparam int L = umrs_pkg::LIMB_W;

	logic                           adv;
	logic                           issue;
	logic [2:0]                     dig_q;
	logic [2:0]                     last_dig;
	logic                           is_first;

	// Lane 0 works on the top 16 bits of the running quotient.
	logic [L-1:0]                   w0_q;
	logic [L-1:0]                   chunk0;
	umrs_pkg::divmod_t              res0;

	logic                           vld_s1;
	logic                           first_s1;
	logic [umrs_pkg::IDX_W-1:0]     idx_s1;
	logic                           last_s1;
	logic [umrs_pkg::COEFF_W-1:0]   r_s1;
	logic [L-1:0]                   xmid_s1;
	logic [L-1:0]                   xlo_s1;
	logic [L-1:0]                   w1_q;
	logic [L-1:0]                   chunk1;
	umrs_pkg::divmod_t              res1;

	logic                           vld_s2;
	logic                           first_s2;
	logic [umrs_pkg::IDX_W-1:0]     idx_s2;
	logic                           last_s2;
	logic [umrs_pkg::COEFF_W-1:0]   r_s2;
	logic [L-1:0]                   xlo_s2;
	logic [L-1:0]                   w2_q;
	logic [L-1:0]                   chunk2;
	umrs_pkg::divmod_t              res2;

	logic                           out_valid_q;
	logic [umrs_pkg::COEFF_W-1:0]   coeff_q;
	logic [umrs_pkg::IDX_W-1:0]     coeff_index_q;
	logic                           last_q;

	assign adv      = !out_valid_q || coeffs.ready;
	assign issue    = adv && job_valid;
	assign last_dig = job.tail ? 3'd3 : 3'd4;
	assign is_first = (dig_q == 3'd0);
	assign job_pop  = issue && (dig_q == last_dig);

	assign chunk0 = is_first ? job.x[2*L +: L] : w0_q;
	assign res0   = umrs_pkg::div769({umrs_pkg::COEFF_W'(0), chunk0});
	assign chunk1 = first_s1 ? xmid_s1 : w1_q;
	assign res1   = umrs_pkg::div769({r_s1, chunk1});
	assign chunk2 = first_s2 ? xlo_s2 : w2_q;
	assign res2   = umrs_pkg::div769({r_s2, chunk2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_q       <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= issue;
			vld_s2      <= vld_s1;
			out_valid_q <= vld_s2;
			if (issue) begin
				dig_q <= job_pop ? 3'd0 : dig_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (issue) begin
				w0_q     <= res0.q;
				r_s1     <= res0.r;
				first_s1 <= is_first;
				idx_s1   <= job.base + umrs_pkg::IDX_W'(dig_q);
				last_s1  <= job.tail && (dig_q == last_dig);
				xmid_s1  <= job.x[L +: L];
				xlo_s1   <= job.x[0 +: L];
			end
			if (vld_s1) begin
				w1_q     <= res1.q;
				r_s2     <= res1.r;
				first_s2 <= first_s1;
				idx_s2   <= idx_s1;
				last_s2  <= last_s1;
				xlo_s2   <= xlo_s1;
			end
			if (vld_s2) begin
				w2_q          <= res2.q;
				coeff_q       <= res2.r;
				coeff_index_q <= idx_s2;
				last_q        <= last_s2;
			end
		end
	end

	assign coeffs.valid       = out_valid_q;
	assign coeffs.coeff       = coeff_q;
	assign coeffs.coeff_index = coeff_index_q;
	assign coeffs.last        = last_q;

	`UMRS_ASSERT(a_coeff_range, out_valid_q |-> (coeff_q < umrs_pkg::Q_MOD), "coefficient not reduced mod 769")
	`UMRS_ASSERT(a_last_index, (out_valid_q && last_q) |-> (coeff_index_q == umrs_pkg::LAST_IDX), "last flag on wrong index")
	`UMRS_NEVER(a_pop_without_job, job_pop && !job_valid, "job retired while queue empty")

endmodule

// File: rtl/core/uniform_mod769_rejection_sampler_top.sv
// Uniform mod-769 rejection sampler.
// The stream channel takes one XOF byte per beat, with new_stream set on the first
// byte of a fresh stream; it restarts sampling from index zero. The coeffs channel
// gives one coefficient per beat with its index, and last is set on the final one.
// A front end gathers words, tests them against 769^5 (six-byte words) or 769^4
// (the five-byte tail word) and drops the unusable bytes of each chunk. Every kept
// word goes into a four-entry job queue. A three-lane long-division pipeline takes
// a word 16 bits per lane and gives one base-769 digit per cycle while the receiver
// keeps up. Throughput: the stream side takes a byte every cycle while the queue
// has room; the back end gives five coefficients per kept six-byte word, so a
// steady stream of one byte per cycle is sustained. A kept word passes through
// the job queue, the s1 and s2 registers and the output register before its first
// coefficient appears; while the receiver keeps up, the others follow one per cycle.
// When the receiver stalls, the output register holds its beat and the division
// pipeline freezes; the queue then fills and the stream side drops ready when it
// is full. Reset clears the queue, the pipeline and the phase state, and sampling
// starts in phase one at index zero.
module uniform_mod769_rejection_sampler_top (
	input  logic       clk,
	input  logic       arst_n,
	umrs_in_if.sink    stream,
	umrs_out_if.source coeffs
);

	umrs_pkg::job_t push_job;
	umrs_pkg::job_t head_job;
	logic           push;
	logic           full;
	logic           pop;
	logic           head_valid;

	// Front end: word gathering, rejection test and chunk bookkeeping.
	umrs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.full   (full),
		.push   (push),
		.job    (push_job)
	);

	// Short queue that lets the front run ahead while the back end works or stalls.
	umrs_job_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (push_job),
		.full    (full),
		.pop     (pop),
		.valid   (head_valid),
		.job_out (head_job)
	);

	// Back end: digit extraction and the output register.
	umrs_digit_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (head_valid),
		.job       (head_job),
		.job_pop   (pop),
		.coeffs    (coeffs)
	);

endmodule

// File: tb/sv/umrs_coeff_checker.sv
module umrs_coeff_checker (
	input  logic clk,
	input  logic arst_n,
	umrs_in_if   stream,
	umrs_out_if  coeffs,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		WIDE_WORDS,
		CHUNK_DRAIN,
		TAIL_WORDS,
		POLY_DONE
	} sample_phase_t;

	typedef struct packed {
		logic [umrs_pkg::COEFF_W-1:0] coeff;
		logic [umrs_pkg::IDX_W-1:0]   coeff_index;
		logic                         last;
	} coeff_beat_t;

	localparam longint unsigned MODULUS   = 769;
	localparam longint unsigned MOD_POW4  = MODULUS * MODULUS * MODULUS * MODULUS;
	localparam longint unsigned MOD_POW5  = MOD_POW4 * MODULUS;
	localparam int              WORD_GOAL = (umrs_pkg::POLY_COEFFS - 4) / 5;
	localparam int              WIDE_SPAN = (umrs_pkg::BIG_CHUNK_BYTES / 6) * 6;
	localparam int              TAIL_SPAN = (umrs_pkg::SMALL_CHUNK_BYTES / 5) * 5;
	localparam logic [7:0]      TOP_BYTE_MASK = 8'h7F;

	coeff_beat_t   coeff_backlog[$];
	sample_phase_t phase;
	logic [47:0]   word_acc;
	int            word_bytes;
	int            chunk_pos;
	int            words_kept;

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] coeffs mismatch: %s", $time, msg);
	endtask

	function automatic void restart_sampling();
		phase      = WIDE_WORDS;
		word_acc   = '0;
		word_bytes = 0;
		chunk_pos  = 0;
		words_kept = 0;
	endfunction

	// Splits a word into base-769 digits, least significant first.
	function automatic void push_digits(input longint unsigned x, input int base, input int n,
			input bit closes_poly);
		coeff_beat_t beat;
		for (int k = 0; k < n; k++) begin
			beat.coeff       = umrs_pkg::COEFF_W'(x % MODULUS);
			beat.coeff_index = umrs_pkg::IDX_W'(base + k);
			beat.last        = closes_poly && (k == n - 1);
			coeff_backlog.push_back(beat);
			x = x / MODULUS;
		end
	endfunction

	function automatic void sample_stream_byte(input logic [7:0] b, input logic fresh);
		longint unsigned word;
		if (fresh)
			restart_sampling();
		case (phase)
			WIDE_WORDS: begin
				if (chunk_pos < WIDE_SPAN) begin
					word_acc[8*word_bytes +: 8] = b;
					word_bytes++;
					if (word_bytes == 6) begin
						word       = longint'(word_acc);
						word_acc   = '0;
						word_bytes = 0;
						if (word < MOD_POW5) begin
							push_digits(word, words_kept * 5, 5, 1'b0);
							words_kept++;
						end
					end
				end
				chunk_pos++;
				if (chunk_pos >= umrs_pkg::BIG_CHUNK_BYTES)
					chunk_pos = 0;
				if (words_kept >= WORD_GOAL) begin
					word_acc   = '0;
					word_bytes = 0;
					phase      = (chunk_pos == 0) ? TAIL_WORDS : CHUNK_DRAIN;
				end
			end
			CHUNK_DRAIN: begin
				chunk_pos++;
				if (chunk_pos >= umrs_pkg::BIG_CHUNK_BYTES) begin
					chunk_pos = 0;
					phase     = TAIL_WORDS;
				end
			end
			TAIL_WORDS: begin
				if (chunk_pos < TAIL_SPAN) begin
					word_acc[8*word_bytes +: 8] = (word_bytes == 4) ? (b & TOP_BYTE_MASK) : b;
					word_bytes++;
					if (word_bytes == 5) begin
						word       = longint'(word_acc[39:0]);
						word_acc   = '0;
						word_bytes = 0;
						if (word < MOD_POW4) begin
							push_digits(word, umrs_pkg::POLY_COEFFS - 4, 4, 1'b1);
							phase     = POLY_DONE;
							chunk_pos = 0;
							return;
						end
					end
				end
				chunk_pos++;
				if (chunk_pos >= umrs_pkg::SMALL_CHUNK_BYTES)
					chunk_pos = 0;
			end
			default: ;
		endcase
	endfunction

	task automatic check_coeff_beat();
		coeff_beat_t want;
		if (coeff_backlog.size() == 0) begin
			report_mismatch($sformatf("unexpected beat coeff=%0d index=%0d last=%0b",
				coeffs.coeff, coeffs.coeff_index, coeffs.last));
			return;
		end
		want = coeff_backlog.pop_front();
		if (coeffs.coeff !== want.coeff)
			report_mismatch($sformatf("index %0d: coeff %0d, want %0d",
				want.coeff_index, coeffs.coeff, want.coeff));
		if (coeffs.coeff_index !== want.coeff_index)
			report_mismatch($sformatf("coeff_index %0d, want %0d",
				coeffs.coeff_index, want.coeff_index));
		if (coeffs.last !== want.last)
			report_mismatch($sformatf("index %0d: last %0b, want %0b",
				want.coeff_index, coeffs.last, want.last));
	endtask

	// A byte accepted at this edge cannot show up on coeffs at the same edge,
	// so the output side is checked first.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_backlog.delete();
			restart_sampling();
			mismatches = 0;
		end else begin
			if (coeffs.valid === 1'b1 && coeffs.ready === 1'b1)
				check_coeff_beat();
			if (stream.valid === 1'b1 && stream.ready === 1'b1)
				sample_stream_byte(stream.stream_byte, stream.new_stream);
		end
		outstanding = coeff_backlog.size();
	end

endmodule

// File: tb/sv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Stimulus-side view of the rejection bound. The checker keeps its own
	// model; these only steer words above or below 769^5.
	localparam longint unsigned Q           = 769;
	localparam longint unsigned POW5        = Q * Q * Q * Q * Q;
	localparam longint unsigned WIDE_RANGE  = 64'd1 << 48;

	// The hang guard is far beyond the slowest legal run: about a hundred
	// stream beats and at most five hundred coefficient beats, each of which
	// might wait out the longest random gap, plus one long receiver hold.
	localparam int unsigned CYCLE_LIMIT  = 200_000;
	localparam int          LONG_HOLD    = 300;
	localparam int          SETTLE_TICKS = 16;

	logic        clk = 1'b0;
	logic        arst_n;
	int          mismatch_count;
	int          coeffs_pending;
	int unsigned cycle_count = 0;

	// Knobs shared between the stimulus and the coeffs receiver. A calm side
	// never idles; a hold request makes the receiver stall for a long stretch.
	bit tx_calm     = 1'b0;
	bit rx_calm     = 1'b0;
	bit rx_hold_req = 1'b0;

	umrs_in_if  stream_if();
	umrs_out_if coeff_if();

	uniform_mod769_rejection_sampler_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.coeffs (coeff_if)
	);

	umrs_coeff_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.stream      (stream_if),
		.coeffs      (coeff_if),
		.mismatches  (mismatch_count),
		.outstanding (coeffs_pending)
	);

	always #1 clk = ~clk;

	// Idle lengths: mostly none, often a few cycles, now and then a long gap.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// Six-byte phase-one word on the chosen side of 769^5, with the bounds
	// themselves and the all-ones word mixed in.
	function automatic logic [47:0] wide_word(input bit keep);
		longint unsigned r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return keep ? 48'd0 : 48'(POW5);
			1: return keep ? 48'(POW5 - 1) : 48'hFFFF_FFFF_FFFF;
			default: begin
				if (keep)
					return 48'(r % POW5);
				else
					return 48'(POW5 + r % (WIDE_RANGE - POW5));
			end
		endcase
	endfunction

	// Offers one byte and returns once its beat completes and any idle gap after
	// it has passed. Valid stays high into the next call when no gap follows, so it
	// is never lowered and raised within the same step.
	task automatic send_byte(input logic [7:0] b, input logic fresh);
		int gap;
		stream_if.valid       <= 1'b1;
		stream_if.stream_byte <= b;
		stream_if.new_stream  <= fresh;
		do @(posedge clk); while (stream_if.ready !== 1'b1);
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			stream_if.valid       <= 1'b0;
			stream_if.stream_byte <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	// Little-endian, as the block gathers its words.
	task automatic send_word(input logic [47:0] w, input int nbytes, input bit fresh);
		for (int i = 0; i < nbytes; i++)
			send_byte(w[8*i +: 8], fresh && (i == 0));
	endtask

	// Sender pause: nothing is offered until every predicted coefficient has
	// come out of the block.
	task automatic pause_until_drained();
		stream_if.valid <= 1'b0;
		do @(posedge clk); while (coeffs_pending != 0);
	endtask

	// A fresh stream of phase-one words. The first sure_keeps words are kept,
	// the others are kept three times out of four.
	task automatic play_words(input int nwords, input int sure_keeps);
		bit keep;
		for (int i = 0; i < nwords; i++) begin
			keep = (i < sure_keeps) || ($urandom_range(0, 3) != 0);
			send_word(wide_word(keep), 6, i == 0);
		end
	endtask

	// Raw random bytes with an occasional restart in the middle.
	task automatic play_noise(input int nbytes);
		for (int i = 0; i < nbytes; i++)
			send_byte(8'($urandom), (i == 0) || ($urandom_range(0, 7) == 0));
	endtask

	// Coeffs receiver. Each pass drives ready once and then waits at least
	// one edge. A hold request is served here by counting cycles, while the
	// stimulus keeps offering bytes, so the job queue fills and the stream
	// side has to drop ready.
	initial begin : coeff_receiver
		int hold;
		coeff_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold        = LONG_HOLD;
			end else if (rx_calm) begin
				hold = 0;
			end else begin
				hold = pick_gap();
			end
			if (hold > 0) begin
				coeff_if.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			coeff_if.ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : stimulus
		arst_n                <= 1'b0;
		stream_if.valid       <= 1'b0;
		stream_if.stream_byte <= '0;
		stream_if.new_stream  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening from the reset state: the zero word, the largest
		// word that is kept (all digits 768), the smallest one that is
		// rejected, then half a word that a restart must throw away before
		// a word worth 769 (digits 0, 1, 0, 0, 0) starting again at index 0.
		send_word(48'd0, 6, 1'b0);
		send_word(48'(POW5 - 1), 6, 1'b0);
		send_word(48'(POW5), 6, 1'b0);
		send_word(48'hA5_5A_FF, 3, 1'b0);
		send_word(48'd769, 6, 1'b1);
		pause_until_drained();

		// The receiver holds off while nine words arrive. At least six are
		// kept, more than the queue and the digit pipeline can take, so the
		// stream side has to stall.
		rx_hold_req = 1'b1;
		play_words(9, 6);
		pause_until_drained();

		// With neither side idling, kept words follow back to back.
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		play_words(3, 3);
		tx_calm = 1'b0;
		rx_calm = 1'b0;

		play_noise(12);

		stream_if.valid <= 1'b0;
		do @(posedge clk); while (coeffs_pending != 0);
		repeat (SETTLE_TICKS) @(posedge clk);
		if (mismatch_count == 0 && coeffs_pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule
